// ----- sv/rgbhsl_pkg.sv -----
// Shared types and constants for the RGB to HSL converter.
package rgbhsl_pkg;

	// pipeline shape
	localparam int NUM_STAGES = 6;
	localparam int DIV_STAGES = 4;

	// divider widths: dividend, divisor, quotient
	localparam int DIV_NUM_W = 23;
	localparam int DIV_DEN_W = 8;
	localparam int DIV_QUO_W = 16;

	// hue sector bases and full turn, degrees times 64
	localparam logic [14:0] HUE_RED   = 15'd0;
	localparam logic [14:0] HUE_GREEN = 15'd7680;
	localparam logic [14:0] HUE_BLUE  = 15'd15360;
	localparam logic [14:0] HUE_FULL  = 15'd23040;

	// which channel holds the maximum
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

endpackage

// ----- sv/rgbhsl_div.sv -----
// Four-stage restoring divider, four quotient bits per stage.
module rgbhsl_div (
	input  logic                               clk,
	input  logic [rgbhsl_pkg::DIV_STAGES-1:0]  en,
	input  logic [rgbhsl_pkg::DIV_NUM_W-1:0]   num,
	input  logic [rgbhsl_pkg::DIV_DEN_W-1:0]   den,
	output logic [rgbhsl_pkg::DIV_QUO_W-1:0]   quo
);
	import rgbhsl_pkg::*;

	// four dependent compare/subtract steps; returns {remainder, quotient bits}
	function automatic logic [11:0] div_step4(input logic [7:0] rem_in,
			input logic [3:0] bits, input logic [7:0] dv);
		logic [8:0] part;
		logic [7:0] rem;
		logic [3:0] q;
		rem = rem_in;
		q = 4'd0;
		for (int i = 3; i >= 0; i--) begin
			part = {rem, bits[i]};
			if (part >= {1'b0, dv}) begin
				part = part - {1'b0, dv};
				q[i] = 1'b1;
			end
			rem = part[7:0];
		end
		return {rem, q};
	endfunction

	logic [7:0]  rem_s1, rem_s2, rem_s3;
	logic [11:0] lo_s1;
	logic [7:0]  lo_s2;
	logic [3:0]  lo_s3;
	logic [7:0]  den_s1, den_s2, den_s3;
	logic [3:0]  q_s1;
	logic [7:0]  q_s2;
	logic [11:0] q_s3;
	logic [15:0] q_s4;

	logic [11:0] st1, st2, st3, st4;

	// top dividend bits seed the remainder; quotient fits 16 bits by range
	assign st1 = div_step4({1'b0, num[22:16]}, num[15:12], den);
	assign st2 = div_step4(rem_s1, lo_s1[11:8], den_s1);
	assign st3 = div_step4(rem_s2, lo_s2[7:4], den_s2);
	assign st4 = div_step4(rem_s3, lo_s3, den_s3);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s1 <= st1[11:4];
			q_s1   <= st1[3:0];
			lo_s1  <= num[11:0];
			den_s1 <= den;
		end
		if (en[1]) begin
			rem_s2 <= st2[11:4];
			q_s2   <= {q_s1, st2[3:0]};
			lo_s2  <= lo_s1[7:0];
			den_s2 <= den_s1;
		end
		if (en[2]) begin
			rem_s3 <= st3[11:4];
			q_s3   <= {q_s2, st3[3:0]};
			lo_s3  <= lo_s2[3:0];
			den_s3 <= den_s2;
		end
		if (en[3]) begin
			q_s4 <= {q_s3, st4[3:0]};
		end
	end

	assign quo = q_s4;

endmodule

// ----- sv/rgb_to_hsl_converter.sv -----
// Top level: pipelined 8-bit RGB to fixed-point HSL converter.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  in      | sink      | in_valid/in_ready  | red, green, blue (8b each)
//  out     | source    | out_valid/out_ready| hue (15b), saturation, luminance
//
// One pixel per clock through six register stages while the output is not
// stalled; out_valid rises when the accepted word reaches stage 6.
// Stage 1 sorts channels and forms dividends, stages 2-5 run the two
// 4-bit-per-stage dividers, stage 6 adds the hue sector base.
// Reset clears only the stage valid bits.
// Each stage holds when the one after it is full and stalled; bubbles
// collapse, so in_ready stays high while any stage is empty.
module rgb_to_hsl_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] hue,
	output logic [15:0] saturation,
	output logic [15:0] luminance
);
	import rgbhsl_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] adv;

	// stage advance: load when empty or when the next stage moves
	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	// stage 1: max/min, sector, hue difference, saturation divisor
	logic [7:0]  mx, mn, dd, mag, sden;
	logic [8:0]  sum, diff, mag9, slo9;
	logic [11:0] hnum;
	logic        neg;
	sector_t     sect;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		sum = {1'b0, mx} + {1'b0, mn};
		dd  = mx - mn;
		// ties resolve red, then green, then blue
		if (mx == red) begin
			sect = SECT_RED;
			diff = {1'b0, green} - {1'b0, blue};
		end else if (mx == green) begin
			sect = SECT_GREEN;
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			sect = SECT_BLUE;
			diff = {1'b0, red} - {1'b0, green};
		end
		neg  = diff[8];
		mag9 = neg ? (9'd0 - diff) : diff;
		mag  = mag9[7:0];
		// 3840*mag = (15*mag) << 8
		hnum = {mag, 4'b0} - {4'b0, mag};
		slo9 = 9'd510 - sum;
		sden = (sum <= 9'd255) ? sum[7:0] : slo9[7:0];
	end

	logic        grey_s1, neg_s1;
	sector_t     sect_s1;
	logic [7:0]  d_s1, sden_s1;
	logic [11:0] hnum_s1;
	logic [8:0]  sum_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			grey_s1 <= (dd == 8'd0);
			neg_s1  <= neg;
			sect_s1 <= sect;
			d_s1    <= dd;
			sden_s1 <= sden;
			hnum_s1 <= hnum;
			sum_s1  <= sum;
		end
	end

	// stages 2-5: saturation and hue quotients
	logic [DIV_QUO_W-1:0] sat_quo, hue_quo;

	rgbhsl_div u_sat_div (
		.clk (clk),
		.en  (adv[DIV_STAGES:1]),
		.num ({d_s1, 15'b0}),
		.den (sden_s1),
		.quo (sat_quo)
	);

	rgbhsl_div u_hue_div (
		.clk (clk),
		.en  (adv[DIV_STAGES:1]),
		.num ({3'b0, hnum_s1, 8'b0}),
		.den (d_s1),
		.quo (hue_quo)
	);

	// luminance: sum*32768/510 = 64*sum + floor(64*sum/255)
	logic [14:0] ly;
	logic [15:0] lt, lum;

	always_comb begin
		ly  = {sum_s1, 6'b0};
		lt  = {1'b0, ly} + {9'b0, ly[14:8]} + 16'd1;
		lum = {1'b0, ly} + {8'b0, lt[15:8]};
	end

	// side data riding along with the dividers
	logic        grey_s2, grey_s3, grey_s4, grey_s5;
	logic        neg_s2, neg_s3, neg_s4, neg_s5;
	sector_t     sect_s2, sect_s3, sect_s4, sect_s5;
	logic [15:0] lum_s2, lum_s3, lum_s4, lum_s5;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			grey_s2 <= grey_s1;
			neg_s2  <= neg_s1;
			sect_s2 <= sect_s1;
			lum_s2  <= lum;
		end
		if (adv[2]) begin
			grey_s3 <= grey_s2;
			neg_s3  <= neg_s2;
			sect_s3 <= sect_s2;
			lum_s3  <= lum_s2;
		end
		if (adv[3]) begin
			grey_s4 <= grey_s3;
			neg_s4  <= neg_s3;
			sect_s4 <= sect_s3;
			lum_s4  <= lum_s3;
		end
		if (adv[4]) begin
			grey_s5 <= grey_s4;
			neg_s5  <= neg_s4;
			sect_s5 <= sect_s4;
			lum_s5  <= lum_s4;
		end
	end

	// stage 6: sector base plus signed quotient, wrap negatives
	logic [14:0] q15, base, hsum;

	always_comb begin
		q15 = {3'b0, hue_quo[11:0]};
		case (sect_s5)
			SECT_RED:   base = HUE_RED;
			SECT_GREEN: base = HUE_GREEN;
			SECT_BLUE:  base = HUE_BLUE;
			default:    base = HUE_RED;
		endcase
		if (!neg_s5) begin
			hsum = base + q15;
		end else if (sect_s5 == SECT_RED) begin
			hsum = (q15 == 15'd0) ? 15'd0 : HUE_FULL - q15;
		end else begin
			hsum = base - q15;
		end
	end

	logic [14:0] hue_s6;
	logic [15:0] sat_s6, lum_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			hue_s6 <= grey_s5 ? 15'd0 : hsum;
			sat_s6 <= grey_s5 ? 16'd0 : sat_quo;
			lum_s6 <= lum_s5;
		end
	end

	assign hue        = hue_s6;
	assign saturation = sat_s6;
	assign luminance  = lum_s6;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the RGB to HSL converter.
module tb;
	import rgbhsl_pkg::*;

	localparam int  CLK_HALF   = 10;
	localparam int  RESET_CYC  = 11;
	localparam int  LONG_HOLD  = 300;
	localparam int  CYCLE_CAP  = 400000;
	localparam int  RAND_ITEMS = 880;

	// one expected result word
	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] sat;
		logic [15:0] lum;
	} hsl_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  red       = 8'd0;
	logic [7:0]  green     = 8'd0;
	logic [7:0]  blue      = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [14:0] hue;
	logic [15:0] saturation;
	logic [15:0] luminance;

	hsl_t hsl_expected[$];
	int   mismatches  = 0;
	int   pixels_sent = 0;
	int   words_seen  = 0;
	int   cycle_cnt   = 0;
	bit   idle_on     = 1'b1;
	bit   hold_req    = 1'b0;

	rgb_to_hsl_converter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hue(hue),
		.saturation(saturation),
		.luminance(luminance)
	);

	always #CLK_HALF clk = ~clk;

	// fixed-point HSL of one pixel
	function automatic hsl_t hsl_of(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		hsl_t    res;
		int      mx, mn, sum, d, diff, q, h, base;
		sector_t sect;
		mx = int'(r);
		mn = int'(r);
		if (int'(g) > mx) mx = int'(g);
		if (int'(b) > mx) mx = int'(b);
		if (int'(g) < mn) mn = int'(g);
		if (int'(b) < mn) mn = int'(b);
		sum = mx + mn;
		d = mx - mn;
		res.lum = 16'((sum * 32768) / 510);
		res.sat = '0;
		res.hue = '0;
		if (d != 0) begin
			if (sum <= 255)
				res.sat = 16'((d * 32768) / sum);
			else
				res.sat = 16'((d * 32768) / (510 - sum));
			// ties resolve red, then green, then blue
			if (mx == int'(r))
				sect = SECT_RED;
			else if (mx == int'(g))
				sect = SECT_GREEN;
			else
				sect = SECT_BLUE;
			case (sect)
				SECT_RED: begin
					base = int'(HUE_RED);
					diff = int'(g) - int'(b);
				end
				SECT_GREEN: begin
					base = int'(HUE_GREEN);
					diff = int'(b) - int'(r);
				end
				default: begin
					base = int'(HUE_BLUE);
					diff = int'(r) - int'(g);
				end
			endcase
			// quotient truncates toward zero
			q = (3840 * (diff < 0 ? -diff : diff)) / d;
			if (diff < 0) q = -q;
			h = base + q;
			if (h < 0) h = h + int'(HUE_FULL);
			res.hue = 15'(h);
		end
		return res;
	endfunction

	// offer one pixel, hold it until taken, then maybe idle
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do
			@(posedge clk);
		while (!in_ready);
		hsl_expected.push_back(hsl_of(r, g, b));
		pixels_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// stop offering and wait for every pending word
	task automatic drain();
		in_valid <= 1'b0;
		while (hsl_expected.size() != 0) @(posedge clk);
	endtask

	// corners, greys, ties and the saturation split
	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd100, 8'd100);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd200, 8'd55, 8'd55);
		send_pixel(8'd200, 8'd56, 8'd56);
		send_pixel(8'd10, 8'd20, 8'd30);
		send_pixel(8'd30, 8'd20, 8'd10);
		send_pixel(8'd20, 8'd30, 8'd10);
		send_pixel(8'd1, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd255);
		send_pixel(8'd170, 8'd85, 8'd255);
		send_pixel(8'd85, 8'd170, 8'd0);
		drain();
	endtask

	// random pixels of mixed shapes with idling on both sides
	task automatic test_random(input int n);
		logic [7:0] r, g, b;
		logic [7:0] corner[4];
		corner = '{8'd0, 8'd1, 8'd254, 8'd255};
		repeat (n) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			case ($urandom_range(0, 3))
				0: ;
				// near grey: tiny delta
				1: begin
					g = r ^ 8'($urandom_range(0, 3));
					b = r ^ 8'($urandom_range(0, 3));
				end
				// two channels tied
				2: case ($urandom_range(0, 2))
					0: g = r;
					1: b = g;
					default: r = b;
				endcase
				default: begin
					if ($urandom_range(0, 1)) r = corner[2'($urandom_range(0, 3))];
					if ($urandom_range(0, 1)) g = corner[2'($urandom_range(0, 3))];
					if ($urandom_range(0, 1)) b = corner[2'($urandom_range(0, 3))];
				end
			endcase
			send_pixel(r, g, b);
		end
		drain();
	endtask

	// output held off while input keeps coming, then a sender pause
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (40)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		drain();
		repeat (20)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		drain();
		repeat (20)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		drain();
	endtask

	// back to back at full rate, no idling
	task automatic test_full_rate();
		idle_on = 1'b0;
		repeat (100)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		drain();
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// compare each output word with the oldest expectation
	always @(posedge clk) begin : check_words
		hsl_t want;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (hsl_expected.size() == 0) begin
				$error("unexpected output word: hue %0d sat %0d lum %0d",
					hue, saturation, luminance);
				mismatches++;
			end else begin
				want = hsl_expected.pop_front();
				if (hue !== want.hue) begin
					$error("hue: expected %0d, actual %0d", want.hue, hue);
					mismatches++;
				end
				if (saturation !== want.sat) begin
					$error("saturation: expected %0d, actual %0d", want.sat, saturation);
					mismatches++;
				end
				if (luminance !== want.lum) begin
					$error("luminance: expected %0d, actual %0d", want.lum, luminance);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_cnt,
				hsl_expected.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(RAND_ITEMS);
		test_backpressure();
		test_full_rate();
		repeat (NUM_STAGES * 4) @(posedge clk);
		$display("Sent %0d pixels, checked %0d words: corners, greys, ties, random shapes,",
			pixels_sent, words_seen);
		$display("a long output hold, a sender pause and a full-rate stretch.");
		if (mismatches == 0 && hsl_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
